// ===== hw/rtl/md5_crypt_password_hash_defines.svh =====
// assertion macros used by md5_crypt_password_hash.sv
`ifndef MD5_CRYPT_PASSWORD_HASH_DEFINES_SVH
`define MD5_CRYPT_PASSWORD_HASH_DEFINES_SVH

// same-cycle implication check
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication check
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/md5c_pkg.sv =====
package md5c_pkg;

   // default sizes
   localparam int MAX_PW_LEN_DEF      = 15;
   localparam int SALT_MAX_DEF        = 8;
   localparam int STRENGTH_ROUNDS_DEF = 1000;

   // md5 initial chaining value
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   // which digest is being built
   typedef enum logic [1:0] {
      KIND_ALT = 2'd0,
      KIND_PRI = 2'd1,
      KIND_RND = 2'd2
   } kind_type;

   // message segment sources
   typedef enum logic [2:0] {
      SEG_PW    = 3'd0,
      SEG_SALT  = 3'd1,
      SEG_MAGIC = 3'd2,
      SEG_ALT   = 3'd3,
      SEG_CUR   = 3'd4,
      SEG_BITS  = 3'd5,
      SEG_SKIP  = 3'd6,
      SEG_END   = 3'd7
   } seg_type;

   // segment program for each digest kind
   function automatic seg_type seg_code(input kind_type kind, input logic [2:0] idx,
                                        input logic odd, input logic m3nz,
                                        input logic m7nz);
      seg_type s;
      s = SEG_END;
      case (kind)
         KIND_ALT: begin
            case (idx)
               3'd0: s = SEG_PW;
               3'd1: s = SEG_SALT;
               3'd2: s = SEG_PW;
               default: s = SEG_END;
            endcase
         end
         KIND_PRI: begin
            case (idx)
               3'd0: s = SEG_PW;
               3'd1: s = SEG_MAGIC;
               3'd2: s = SEG_SALT;
               3'd3: s = SEG_ALT;
               3'd4: s = SEG_BITS;
               default: s = SEG_END;
            endcase
         end
         KIND_RND: begin
            case (idx)
               3'd0: s = odd ? SEG_PW : SEG_CUR;
               3'd1: s = m3nz ? SEG_SALT : SEG_SKIP;
               3'd2: s = m7nz ? SEG_PW : SEG_SKIP;
               3'd3: s = odd ? SEG_CUR : SEG_PW;
               default: s = SEG_END;
            endcase
         end
         default: s = SEG_END;
      endcase
      return s;
   endfunction

   // number of significant bits of a length
   function automatic logic [4:0] bit_len(input logic [4:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 5; i++) begin
         if (v[i]) n = 5'(i + 1);
      end
      return n;
   endfunction

   // md5 message word index per step
   function automatic logic [3:0] md5_g(input logic [5:0] i);
      logic [3:0] j;
      logic [3:0] g;
      j = i[3:0];
      case (i[5:4])
         2'd0: g = j;
         2'd1: g = 4'(j * 4'd5 + 4'd1);
         2'd2: g = 4'(j * 4'd3 + 4'd5);
         default: g = 4'(j * 4'd7);
      endcase
      return g;
   endfunction

   // md5 rotate amounts
   function automatic logic [4:0] md5_s(input logic [3:0] idx);
      logic [4:0] s;
      case (idx)
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
   endfunction

   // md5 additive constants
   function automatic logic [31:0] md5_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   // crypt base-64 alphabet
   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] c;
      if (v < 6'd2)       c = 7'(7'd46 + 7'(v));
      else if (v < 6'd12) c = 7'(7'd46 + 7'(v));
      else if (v < 6'd38) c = 7'(7'd53 + 7'(v));
      else                c = 7'(7'd59 + 7'(v));
      return c;
   endfunction

endpackage

// ===== hw/rtl/md5_crypt_password_hash.sv =====
// md5-crypt ($1$) password hash with a caller-supplied salt. Load the password bytes
// (tuser low), then the salt bytes (tuser high); the salt byte with tlast starts the hash.
// Password bytes beyond MAX_PW_LEN set an overflow and the load then ends in a single
// result with tuser (too long) and tlast set and no hash. Salt bytes beyond SALT_MAX are
// dropped. Otherwise 22 base-64 characters of the final digest follow, the last with
// tlast. Loading takes a byte whenever one is offered. One md5 round unit does one step
// per cycle: each of the 2 + STRENGTH_ROUNDS digests first writes its message one byte
// at a time, segment by segment, then starts the rounds, runs the 64 round steps and
// ends with a finish step that adds the initial chaining value.
// No input is taken while hashing or while characters are being sent.
module md5_crypt_password_hash #(
   parameter int MAX_PW_LEN      = md5c_pkg::MAX_PW_LEN_DEF,
   parameter int SALT_MAX        = md5c_pkg::SALT_MAX_DEF,
   parameter int STRENGTH_ROUNDS = md5c_pkg::STRENGTH_ROUNDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] is_salt
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic       rsp_tuser,   // [0] too_long
   output logic       rsp_tlast    // last_char
);
   import md5c_pkg::*;
   `include "md5_crypt_password_hash_defines.svh"

   localparam int PL_W     = $clog2(MAX_PW_LEN + 1);
   localparam int SL_W     = $clog2(SALT_MAX + 1);
   localparam int PW_IDX_W = (MAX_PW_LEN > 1) ? $clog2(MAX_PW_LEN) : 1;
   localparam int SA_IDX_W = (SALT_MAX > 1) ? $clog2(SALT_MAX) : 1;
   localparam int RC_W     = $clog2(STRENGTH_ROUNDS + 1);

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_BUILD = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_DONE  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   kind_type        kind_ff;
   logic [7:0]      pw_ff [MAX_PW_LEN];
   logic [7:0]      salt_ff [SALT_MAX];
   logic [PL_W-1:0] pwlen_ff;
   logic [SL_W-1:0] saltlen_ff;
   logic            ovf_ff;
   logic            err_ff;
   logic [31:0]     msg_ff [16];
   logic [5:0]      mlen_ff;
   logic [2:0]      seg_ff;
   logic [4:0]      pos_ff;
   logic [5:0]      rnd_ff;
   logic [31:0]     a_ff, b_ff, c_ff, d_ff;
   logic [127:0]    dig_ff;
   logic [127:0]    alt_ff;
   logic [RC_W-1:0] rcnt_ff;
   logic [1:0]      m3_ff;
   logic [2:0]      m7_ff;
   logic [4:0]      oidx_ff;

   logic            req_hs, rsp_hs;
   seg_type         seg;
   logic [4:0]      seg_len;
   logic [7:0]      seg_byte;
   logic [3:0]      g_idx;
   logic [31:0]     m_word;
   logic [31:0]     f_val, sum, rot;
   logic [63:0]     rot_wide;
   logic [4:0]      sh;
   logic [2:0]      grp;
   logic [23:0]     grp_val;
   logic [23:0]     grp_sh;
   logic [3:0]      ib0, ib1, ib2;
   logic [127:0]    fin;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_hs     = req_tvalid && req_tready;
   assign rsp_hs     = rsp_tvalid && rsp_tready;

   // segment program and its length and byte source
   always_comb begin
      seg = seg_code(kind_ff, seg_ff, rcnt_ff[0], (m3_ff != 2'd0), (m7_ff != 3'd0));
      case (seg)
         SEG_PW:    seg_len = 5'(pwlen_ff);
         SEG_SALT:  seg_len = 5'(saltlen_ff);
         SEG_MAGIC: seg_len = 5'd3;
         SEG_ALT:   seg_len = 5'(pwlen_ff);
         SEG_CUR:   seg_len = 5'd16;
         SEG_BITS:  seg_len = bit_len(5'(pwlen_ff));
         default:   seg_len = 5'd0;
      endcase
      case (seg)
         SEG_PW:    seg_byte = pw_ff[pos_ff[PW_IDX_W-1:0]];
         SEG_SALT:  seg_byte = salt_ff[pos_ff[SA_IDX_W-1:0]];
         SEG_MAGIC: seg_byte = (pos_ff == 5'd1) ? 8'h31 : 8'h24;
         SEG_ALT:   seg_byte = alt_ff[8*pos_ff[3:0] +: 8];
         SEG_CUR:   seg_byte = dig_ff[8*pos_ff[3:0] +: 8];
         SEG_BITS:  seg_byte = ((5'(pwlen_ff) >> pos_ff) & 5'd1) != 5'd0 ? 8'h00 : pw_ff[0];
         default:   seg_byte = 8'h00;
      endcase
   end

   // padded message word for the current step
   always_comb begin
      g_idx  = md5_g(rnd_ff);
      m_word = 32'd0;
      if (g_idx == 4'd14) begin
         m_word = {23'd0, mlen_ff, 3'd0};
      end else if (g_idx != 4'd15) begin
         for (int k = 0; k < 4; k++) begin
            if ({g_idx, 2'(k)} < mlen_ff)
               m_word[8*k +: 8] = msg_ff[g_idx][8*k +: 8];
            else if ({g_idx, 2'(k)} == mlen_ff)
               m_word[8*k +: 8] = 8'h80;
         end
      end
   end

   // shared md5 round unit
   always_comb begin
      case (rnd_ff[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sh       = md5_s({rnd_ff[5:4], rnd_ff[1:0]});
      sum      = a_ff + f_val + md5_k(rnd_ff) + m_word;
      rot_wide = {sum, sum} << sh;
      rot      = rot_wide[63:32];
      fin      = {d_ff + IV_D, c_ff + IV_C, b_ff + IV_B, a_ff + IV_A};
   end

   // output character select
   always_comb begin
      grp = oidx_ff[4:2];
      ib0 = 4'(grp);
      ib1 = 4'(4'(grp) + 4'd6);
      ib2 = (grp == 3'd4) ? 4'd5 : 4'(4'(grp) + 4'd12);
      if (grp == 3'd5)
         grp_val = {16'd0, dig_ff[8*11 +: 8]};
      else
         grp_val = {dig_ff[8*ib0 +: 8], dig_ff[8*ib1 +: 8], dig_ff[8*ib2 +: 8]};
      grp_sh = grp_val >> (5'(oidx_ff[1:0]) * 5'd6);
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = err_ff ? 8'd0 : {1'b0, b64_char(grp_sh[5:0])};
   assign rsp_tuser  = err_ff;
   assign rsp_tlast  = err_ff || (oidx_ff == 5'd21);

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_hs && req_tuser && req_tlast) state_in = ovf_ff ? ST_OUT : ST_BUILD;
         end
         ST_BUILD: begin
            if (seg == SEG_END) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == 6'd63) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (kind_ff == KIND_RND && rcnt_ff == RC_W'(STRENGTH_ROUNDS - 1))
               state_in = ST_OUT;
            else
               state_in = ST_BUILD;
         end
         ST_OUT: begin
            if (rsp_hs && rsp_tlast) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         kind_ff    <= KIND_ALT;
         pwlen_ff   <= '0;
         saltlen_ff <= '0;
         ovf_ff     <= 1'b0;
         err_ff     <= 1'b0;
         mlen_ff    <= 6'd0;
         seg_ff     <= 3'd0;
         pos_ff     <= 5'd0;
         rnd_ff     <= 6'd0;
         rcnt_ff    <= '0;
         m3_ff      <= 2'd0;
         m7_ff      <= 3'd0;
         oidx_ff    <= 5'd0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_LOAD: begin
               if (req_hs) begin
                  if (!req_tuser) begin
                     if (pwlen_ff < PL_W'(MAX_PW_LEN)) pwlen_ff <= PL_W'(pwlen_ff + 1'b1);
                     else ovf_ff <= 1'b1;
                  end else begin
                     if (saltlen_ff < SL_W'(SALT_MAX)) saltlen_ff <= SL_W'(saltlen_ff + 1'b1);
                     if (req_tlast) begin
                        err_ff  <= ovf_ff;
                        kind_ff <= KIND_ALT;
                        mlen_ff <= 6'd0;
                        seg_ff  <= 3'd0;
                        pos_ff  <= 5'd0;
                        oidx_ff <= 5'd0;
                     end
                  end
               end
            end
            ST_BUILD: begin
               if (seg == SEG_END) begin
                  rnd_ff <= 6'd0;
               end else if (pos_ff < seg_len) begin
                  mlen_ff <= 6'(mlen_ff + 6'd1);
                  pos_ff  <= 5'(pos_ff + 5'd1);
               end else begin
                  pos_ff <= 5'd0;
                  seg_ff <= 3'(seg_ff + 3'd1);
               end
            end
            ST_ROUND: begin
               rnd_ff <= 6'(rnd_ff + 6'd1);
            end
            ST_DONE: begin
               mlen_ff <= 6'd0;
               seg_ff  <= 3'd0;
               pos_ff  <= 5'd0;
               case (kind_ff)
                  KIND_ALT: kind_ff <= KIND_PRI;
                  KIND_PRI: begin
                     kind_ff <= KIND_RND;
                     rcnt_ff <= '0;
                     m3_ff   <= 2'd0;
                     m7_ff   <= 3'd0;
                  end
                  default: begin
                     rcnt_ff <= RC_W'(rcnt_ff + 1'b1);
                     m3_ff   <= (m3_ff == 2'd2) ? 2'd0 : 2'(m3_ff + 2'd1);
                     m7_ff   <= (m7_ff == 3'd6) ? 3'd0 : 3'(m7_ff + 3'd1);
                  end
               endcase
            end
            ST_OUT: begin
               if (rsp_hs) begin
                  oidx_ff <= 5'(oidx_ff + 5'd1);
                  if (rsp_tlast) begin
                     pwlen_ff   <= '0;
                     saltlen_ff <= '0;
                     ovf_ff     <= 1'b0;
                     err_ff     <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // payload: stores, message buffer, round registers, digests
   always_ff @(posedge clock) begin
      if (req_hs && !req_tuser && pwlen_ff < PL_W'(MAX_PW_LEN))
         pw_ff[pwlen_ff[PW_IDX_W-1:0]] <= req_tdata;
      if (req_hs && req_tuser && saltlen_ff < SL_W'(SALT_MAX))
         salt_ff[saltlen_ff[SA_IDX_W-1:0]] <= req_tdata;
      if (state_ff == ST_BUILD && seg != SEG_END && pos_ff < seg_len)
         msg_ff[mlen_ff[5:2]][8*mlen_ff[1:0] +: 8] <= seg_byte;
      if (state_ff == ST_BUILD && seg == SEG_END) begin
         a_ff <= IV_A;
         b_ff <= IV_B;
         c_ff <= IV_C;
         d_ff <= IV_D;
      end else if (state_ff == ST_ROUND) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_ff + rot;
      end
      if (state_ff == ST_DONE) begin
         dig_ff <= fin;
         if (kind_ff == KIND_ALT) alt_ff <= fin;
      end
   end

   // checks
   `CHK_IMPLY(a_one_side, clock, reset, rsp_tvalid, !req_tready, "input taken while sending")
   `CHK_IMPLY(a_msg_fits, clock, reset, state_ff == ST_ROUND, mlen_ff <= 6'd55,
              "message exceeds one block")
   `CHK_IMPLY(a_err_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast,
              "error result not marked last")
   `CHK_NEXT(a_round_end, clock, reset, state_ff == ST_ROUND && rnd_ff == 6'd63,
             state_ff == ST_DONE, "compression did not finish after 64 steps")

endmodule
